>>> rtl/sebt_pkg.sv
package sebt_pkg;

  // result queue geometry
  localparam int MaxRes = 4;
  localparam int ResCw  = 3;
  localparam int QDepth = 8;
  localparam int QAw    = 3;
  localparam int QCw    = 4;

  // character values
  localparam logic [7:0] ChNl     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChVt     = 8'h0b;
  localparam logic [7:0] ChFf     = 8'h0c;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChOpen   = 8'h28;
  localparam logic [7:0] ChClose  = 8'h29;
  localparam logic [7:0] ChSemi   = 8'h3b;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChThree  = 8'h33;
  localparam logic [7:0] ChSeven  = 8'h37;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpF    = 8'h46;
  localparam logic [7:0] ChLowN   = 8'h6e;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowX   = 8'h78;

  typedef enum logic [3:0] {
    KIND_NL    = 4'd0,
    KIND_OPEN  = 4'd1,
    KIND_CLOSE = 4'd2,
    KIND_ABYTE = 4'd3,
    KIND_AEND  = 4'd4,
    KIND_SBYTE = 4'd5,
    KIND_SEND  = 4'd6,
    KIND_EOI   = 4'd7,
    KIND_ERR   = 4'd8
  } kind_t;

  typedef enum logic [8:0] {
    MODE_IDLE    = 9'b000000001,
    MODE_COMMENT = 9'b000000010,
    MODE_ATOM    = 9'b000000100,
    MODE_STR     = 9'b000001000,
    MODE_ESC     = 9'b000010000,
    MODE_OCT     = 9'b000100000,
    MODE_HEX1    = 9'b001000000,
    MODE_HEX2    = 9'b010000000,
    MODE_DEAD    = 9'b100000000
  } mode_t;

  // results of one item, in order
  typedef struct packed {
    kind_t [MaxRes-1:0]      kind;
    logic  [MaxRes-1:0][7:0] data;
    logic  [ResCw-1:0]       cnt;
  } res_list_t;

  function automatic res_list_t add_res(res_list_t l, kind_t k, logic [7:0] b);
    res_list_t r;
    r = l;
    if (l.cnt < ResCw'(MaxRes)) begin
      r.kind[l.cnt[1:0]] = k;
      r.data[l.cnt[1:0]] = b;
      r.cnt = l.cnt + ResCw'(1);
    end
    return r;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChVt) || (c == ChFf) || (c == ChCr);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return (c >= ChZero && c <= ChNine) || (c >= ChLowA && c <= ChLowF) ||
           (c >= ChUpA && c <= ChUpF);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= ChZero && c <= ChNine) v = c - ChZero;
    else if (c >= ChLowA && c <= ChLowF) v = c - ChLowA + 8'd10;
    else if (c >= ChUpA && c <= ChUpF) v = c - ChUpA + 8'd10;
    return v[3:0];
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return (c >= ChZero) && (c <= ChSeven);
  endfunction

  // text left over from an escape that did not complete
  function automatic res_list_t flush_pending(res_list_t l, mode_t m, logic [7:0] ov,
                                              logic [7:0] hh);
    res_list_t r;
    r = l;
    case (m)
      MODE_ESC: r = add_res(r, KIND_SBYTE, ChBslash);
      MODE_OCT: r = add_res(r, KIND_SBYTE, ov);
      MODE_HEX1: begin
        r = add_res(r, KIND_SBYTE, ChBslash);
        r = add_res(r, KIND_SBYTE, ChLowX);
      end
      MODE_HEX2: begin
        r = add_res(r, KIND_SBYTE, ChBslash);
        r = add_res(r, KIND_SBYTE, ChLowX);
        r = add_res(r, KIND_SBYTE, hh);
      end
      default: r = l;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] quote_char(logic qs);
    return qs ? ChSquote : ChDquote;
  endfunction

  function automatic res_list_t string_res(res_list_t l, logic [7:0] c, logic qs);
    res_list_t r;
    r = l;
    if (c == quote_char(qs)) r = add_res(r, KIND_SEND, 8'd0);
    else if (c == ChBslash) r = l;
    else if (c == ChNl) r = add_res(r, KIND_ERR, 8'd0);
    else r = add_res(r, KIND_SBYTE, c);
    return r;
  endfunction

  function automatic mode_t string_mode(logic [7:0] c, logic qs);
    mode_t m;
    if (c == quote_char(qs)) m = MODE_IDLE;
    else if (c == ChBslash) m = MODE_ESC;
    else if (c == ChNl) m = MODE_DEAD;
    else m = MODE_STR;
    return m;
  endfunction

  function automatic res_list_t between_res(res_list_t l, logic [7:0] c);
    res_list_t r;
    r = l;
    if (c == ChNl) r = add_res(r, KIND_NL, 8'd0);
    else if (c == ChOpen) r = add_res(r, KIND_OPEN, 8'd0);
    else if (c == ChClose) r = add_res(r, KIND_CLOSE, 8'd0);
    else if (c == ChDquote || c == ChSquote || c == ChSemi || is_blank(c)) r = l;
    else r = add_res(r, KIND_ABYTE, c);
    return r;
  endfunction

  function automatic mode_t between_mode(logic [7:0] c);
    mode_t m;
    if (c == ChNl || c == ChOpen || c == ChClose || is_blank(c)) m = MODE_IDLE;
    else if (c == ChDquote || c == ChSquote) m = MODE_STR;
    else if (c == ChSemi) m = MODE_COMMENT;
    else m = MODE_ATOM;
    return m;
  endfunction

endpackage

>>> rtl/s_expression_byte_tokenizer_top.sv
// s-expression tokenizer: one source byte (or an end mark, in_tuser high) per item in,
// a stream of tokens out. blanks and ';' comments are dropped; newline and parens become
// tokens, atom bytes pass through and close with an atom-end token, quoted strings are
// unescaped and close with string-end. an input item is taken every cycle as long as the
// 8-entry result queue has room for all results the byte causes (up to four); a byte
// that causes one result sustains one item per clock. after a newline inside a string
// the error token is sent and bytes are dropped until the next end mark; an end mark
// inside a string also sends the error token. every end mark returns the tokenizer to
// its reset state.
module s_expression_byte_tokenizer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] is_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [3:0] out_tuser,  // [3:0] kind
  output logic       out_tlast
);

  // input register
  logic                in_valid_r;
  logic [7:0]          in_byte_r;
  logic                in_end_r;
  logic                load;
  logic                commit;
  logic                room;
  sebt_pkg::res_list_t res;

  // the held item is decoded and its results pushed in the same cycle
  assign commit    = in_valid_r && room;
  assign in_tready = !in_valid_r || room;
  assign load      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (load) begin
      in_valid_r <= 1'b1;
    end else if (commit) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tuser;
    end
  end

  // decode of one byte against the tokenizer state
  sebt_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_i   (in_byte_r),
    .end_i    (in_end_r),
    .commit_i (commit),
    .res_o    (res)
  );

  // result queue, one token per cycle out while out_tready is high
  sebt_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_i      (res),
    .push_i     (commit),
    .room_o     (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  // an end mark always produces at least one token
  a_end_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    commit && in_end_r |-> res.cnt != '0)
    else $error("end mark produced no result");

  // a committed token is visible on the next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit && res.cnt != '0 |=> out_tvalid)
    else $error("pushed result not presented");

  // an item is never committed twice
  a_single_commit: assert property (@(posedge clk) disable iff (!rst_n)
    commit && !load |=> !commit)
    else $error("item committed twice");
`endif

endmodule

>>> rtl/sebt_step.sv
module sebt_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            byte_i,
  input  logic                  end_i,
  input  logic                  commit_i,
  output sebt_pkg::res_list_t   res_o
);

  sebt_pkg::mode_t     mode_r, mode_nxt;
  logic                qs_r, qs_nxt;
  logic [7:0]          ov_r, ov_nxt;
  logic [1:0]          dl_r, dl_nxt;
  logic [7:0]          hh_r, hh_nxt;
  sebt_pkg::res_list_t l;
  logic [7:0]          ov_acc;
  logic [1:0]          dl_dec;

  assign ov_acc = {ov_r[4:0], byte_i[2:0]};
  assign dl_dec = dl_r - 2'd1;

  always_comb begin
    l        = '0;
    mode_nxt = mode_r;
    qs_nxt   = qs_r;
    ov_nxt   = ov_r;
    dl_nxt   = dl_r;
    hh_nxt   = hh_r;
    if (end_i) begin
      if (mode_r == sebt_pkg::MODE_ATOM) begin
        l = sebt_pkg::add_res(l, sebt_pkg::KIND_AEND, 8'd0);
        l = sebt_pkg::add_res(l, sebt_pkg::KIND_EOI, 8'd0);
      end else if (mode_r == sebt_pkg::MODE_STR || mode_r == sebt_pkg::MODE_ESC ||
                   mode_r == sebt_pkg::MODE_OCT || mode_r == sebt_pkg::MODE_HEX1 ||
                   mode_r == sebt_pkg::MODE_HEX2) begin
        l = sebt_pkg::flush_pending(l, mode_r, ov_r, hh_r);
        l = sebt_pkg::add_res(l, sebt_pkg::KIND_ERR, 8'd0);
      end else begin
        l = sebt_pkg::add_res(l, sebt_pkg::KIND_EOI, 8'd0);
      end
      mode_nxt = sebt_pkg::MODE_IDLE;
      qs_nxt   = 1'b0;
      ov_nxt   = 8'd0;
      dl_nxt   = 2'd0;
      hh_nxt   = 8'd0;
    end else begin
      case (mode_r)
        sebt_pkg::MODE_COMMENT: begin
          if (byte_i == sebt_pkg::ChNl) begin
            l = sebt_pkg::add_res(l, sebt_pkg::KIND_NL, 8'd0);
            mode_nxt = sebt_pkg::MODE_IDLE;
          end
        end
        sebt_pkg::MODE_ATOM: begin
          if (sebt_pkg::is_blank(byte_i) || byte_i == sebt_pkg::ChNl ||
              byte_i == sebt_pkg::ChDquote || byte_i == sebt_pkg::ChSquote ||
              byte_i == sebt_pkg::ChOpen || byte_i == sebt_pkg::ChClose ||
              byte_i == sebt_pkg::ChSemi) begin
            l = sebt_pkg::add_res(l, sebt_pkg::KIND_AEND, 8'd0);
            l = sebt_pkg::between_res(l, byte_i);
            mode_nxt = sebt_pkg::between_mode(byte_i);
            if (byte_i == sebt_pkg::ChDquote || byte_i == sebt_pkg::ChSquote)
              qs_nxt = (byte_i == sebt_pkg::ChSquote);
          end else begin
            l = sebt_pkg::add_res(l, sebt_pkg::KIND_ABYTE, byte_i);
          end
        end
        sebt_pkg::MODE_STR: begin
          l = sebt_pkg::string_res(l, byte_i, qs_r);
          mode_nxt = sebt_pkg::string_mode(byte_i, qs_r);
          if (byte_i == sebt_pkg::quote_char(qs_r)) qs_nxt = 1'b0;
        end
        sebt_pkg::MODE_ESC: begin
          mode_nxt = sebt_pkg::MODE_STR;
          if (byte_i == sebt_pkg::ChDquote || byte_i == sebt_pkg::ChSquote ||
              byte_i == sebt_pkg::ChBslash) begin
            l = sebt_pkg::add_res(l, sebt_pkg::KIND_SBYTE, byte_i);
          end else if (byte_i == sebt_pkg::ChLowN) begin
            l = sebt_pkg::add_res(l, sebt_pkg::KIND_SBYTE, sebt_pkg::ChNl);
          end else if (byte_i == sebt_pkg::ChLowR) begin
            l = sebt_pkg::add_res(l, sebt_pkg::KIND_SBYTE, sebt_pkg::ChCr);
          end else if (byte_i == sebt_pkg::ChLowT) begin
            l = sebt_pkg::add_res(l, sebt_pkg::KIND_SBYTE, sebt_pkg::ChTab);
          end else if (sebt_pkg::is_octal(byte_i)) begin
            ov_nxt   = {5'd0, byte_i[2:0]};
            dl_nxt   = (byte_i <= sebt_pkg::ChThree) ? 2'd2 : 2'd1;
            mode_nxt = sebt_pkg::MODE_OCT;
          end else if (byte_i == sebt_pkg::ChLowX) begin
            mode_nxt = sebt_pkg::MODE_HEX1;
          end else begin
            // unknown escape: literal backslash, byte is plain text
            l = sebt_pkg::add_res(l, sebt_pkg::KIND_SBYTE, sebt_pkg::ChBslash);
            l = sebt_pkg::string_res(l, byte_i, qs_r);
            mode_nxt = sebt_pkg::string_mode(byte_i, qs_r);
            if (byte_i == sebt_pkg::quote_char(qs_r)) qs_nxt = 1'b0;
          end
        end
        sebt_pkg::MODE_OCT: begin
          if (sebt_pkg::is_octal(byte_i) && dl_r != 2'd0) begin
            ov_nxt = ov_acc;
            dl_nxt = dl_dec;
            if (dl_dec == 2'd0) begin
              l = sebt_pkg::add_res(l, sebt_pkg::KIND_SBYTE, ov_acc);
              mode_nxt = sebt_pkg::MODE_STR;
              ov_nxt   = 8'd0;
            end
          end else begin
            l = sebt_pkg::flush_pending(l, mode_r, ov_r, hh_r);
            ov_nxt = 8'd0;
            dl_nxt = 2'd0;
            l = sebt_pkg::string_res(l, byte_i, qs_r);
            mode_nxt = sebt_pkg::string_mode(byte_i, qs_r);
            if (byte_i == sebt_pkg::quote_char(qs_r)) qs_nxt = 1'b0;
          end
        end
        sebt_pkg::MODE_HEX1: begin
          if (sebt_pkg::is_hex(byte_i)) begin
            hh_nxt   = byte_i;
            mode_nxt = sebt_pkg::MODE_HEX2;
          end else begin
            l = sebt_pkg::flush_pending(l, mode_r, ov_r, hh_r);
            l = sebt_pkg::string_res(l, byte_i, qs_r);
            mode_nxt = sebt_pkg::string_mode(byte_i, qs_r);
            if (byte_i == sebt_pkg::quote_char(qs_r)) qs_nxt = 1'b0;
          end
        end
        sebt_pkg::MODE_HEX2: begin
          hh_nxt = 8'd0;
          if (sebt_pkg::is_hex(byte_i)) begin
            l = sebt_pkg::add_res(l, sebt_pkg::KIND_SBYTE,
                                  {sebt_pkg::hex_val(hh_r), sebt_pkg::hex_val(byte_i)});
            mode_nxt = sebt_pkg::MODE_STR;
          end else begin
            l = sebt_pkg::flush_pending(l, mode_r, ov_r, hh_r);
            l = sebt_pkg::string_res(l, byte_i, qs_r);
            mode_nxt = sebt_pkg::string_mode(byte_i, qs_r);
            if (byte_i == sebt_pkg::quote_char(qs_r)) qs_nxt = 1'b0;
          end
        end
        sebt_pkg::MODE_DEAD: begin
          mode_nxt = sebt_pkg::MODE_DEAD;
        end
        default: begin
          l = sebt_pkg::between_res(l, byte_i);
          mode_nxt = sebt_pkg::between_mode(byte_i);
          if (byte_i == sebt_pkg::ChDquote || byte_i == sebt_pkg::ChSquote)
            qs_nxt = (byte_i == sebt_pkg::ChSquote);
        end
      endcase
    end
  end

  assign res_o = l;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sebt_pkg::MODE_IDLE;
      qs_r   <= 1'b0;
      ov_r   <= 8'd0;
      dl_r   <= 2'd0;
      hh_r   <= 8'd0;
    end else if (commit_i) begin
      mode_r <= mode_nxt;
      qs_r   <= qs_nxt;
      ov_r   <= ov_nxt;
      dl_r   <= dl_nxt;
      hh_r   <= hh_nxt;
    end
  end

endmodule

>>> rtl/sebt_outq.sv
module sebt_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  sebt_pkg::res_list_t res_i,
  input  logic                push_i,
  output logic                room_o,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic [3:0]          out_tuser,
  output logic                out_tlast
);

  sebt_pkg::kind_t               kind_q [sebt_pkg::QDepth];
  logic [7:0]                    data_q [sebt_pkg::QDepth];
  logic                          last_q [sebt_pkg::QDepth];
  logic [sebt_pkg::QAw-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [sebt_pkg::QAw-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [sebt_pkg::QCw-1:0]      count_r, count_nxt;
  logic [sebt_pkg::QCw-1:0]      n_push;
  logic                          pop;

  assign n_push = push_i ? sebt_pkg::QCw'(res_i.cnt) : '0;
  assign room_o = (count_r + sebt_pkg::QCw'(res_i.cnt)) <= sebt_pkg::QCw'(sebt_pkg::QDepth);
  assign pop    = out_tvalid && out_tready;

  assign out_tvalid = count_r != '0;
  assign out_tuser  = kind_q[rd_ptr_r];
  assign out_tdata  = data_q[rd_ptr_r];
  assign out_tlast  = last_q[rd_ptr_r];

  assign wr_ptr_nxt = wr_ptr_r + sebt_pkg::QAw'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + sebt_pkg::QAw'(pop);
  assign count_nxt  = count_r + n_push - sebt_pkg::QCw'(pop);

  // all results of one item land in the same cycle
  always_ff @(posedge clk) begin
    for (int i = 0; i < sebt_pkg::MaxRes; i++) begin
      if (push_i && sebt_pkg::ResCw'(i) < res_i.cnt) begin
        kind_q[wr_ptr_r + sebt_pkg::QAw'(i)] <= res_i.kind[i];
        data_q[wr_ptr_r + sebt_pkg::QAw'(i)] <= res_i.data[i];
        last_q[wr_ptr_r + sebt_pkg::QAw'(i)] <= (sebt_pkg::ResCw'(i + 1) == res_i.cnt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sebt_pkg::QCw'(sebt_pkg::QDepth))
    else $error("result queue overfilled");
`endif

endmodule

>>> verif/sebt_token_checker.sv
module sebt_token_checker
  import sebt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic [3:0] out_tuser,
  input  logic       out_tlast,
  output int         mismatches,
  output int         tokens_waiting,
  output int         tokens_seen,
  output int         items_seen
);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } token_t;

  token_t tokens_due[$];
  token_t step_tokens[$];

  // lexer state
  mode_t      lex_mode;
  logic       single_q;
  logic [7:0] oct_acc;
  logic [1:0] oct_left;
  logic [7:0] hex_held;

  function void clear_lexer();
    lex_mode = MODE_IDLE;
    single_q = 1'b0;
    oct_acc  = 8'h00;
    oct_left = 2'd0;
    hex_held = 8'h00;
  endfunction

  function void add_token(kind_t k, logic [7:0] v);
    token_t t;
    t.kind  = k;
    t.value = v;
    t.last  = 1'b0;
    if (step_tokens.size() < MaxRes) step_tokens.push_back(t);
  endfunction

  function bit skip_char(logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChVt || c == ChFf || c == ChCr;
  endfunction

  function int hex_digit(logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return int'(c - ChZero);
    if (c >= ChLowA && c <= ChLowF) return int'(c - ChLowA) + 10;
    if (c >= ChUpA && c <= ChUpF) return int'(c - ChUpA) + 10;
    return -1;
  endfunction

  function void start_token(logic [7:0] c);
    lex_mode = MODE_IDLE;
    if (c == ChNl) add_token(KIND_NL, 8'h00);
    else if (c == ChOpen) add_token(KIND_OPEN, 8'h00);
    else if (c == ChClose) add_token(KIND_CLOSE, 8'h00);
    else if (c == ChDquote || c == ChSquote) begin
      lex_mode = MODE_STR;
      single_q = (c == ChSquote);
    end else if (c == ChSemi) lex_mode = MODE_COMMENT;
    else if (!skip_char(c)) begin
      add_token(KIND_ABYTE, c);
      lex_mode = MODE_ATOM;
    end
  endfunction

  function void string_char(logic [7:0] c);
    lex_mode = MODE_STR;
    if (c == (single_q ? ChSquote : ChDquote)) begin
      add_token(KIND_SEND, 8'h00);
      lex_mode = MODE_IDLE;
      single_q = 1'b0;
    end else if (c == ChBslash) lex_mode = MODE_ESC;
    else if (c == ChNl) begin
      add_token(KIND_ERR, 8'h00);
      lex_mode = MODE_DEAD;
    end else add_token(KIND_SBYTE, c);
  endfunction

  function void escape_char(logic [7:0] c);
    lex_mode = MODE_STR;
    if (c == ChDquote || c == ChSquote || c == ChBslash) add_token(KIND_SBYTE, c);
    else if (c == ChLowN) add_token(KIND_SBYTE, ChNl);
    else if (c == ChLowR) add_token(KIND_SBYTE, ChCr);
    else if (c == ChLowT) add_token(KIND_SBYTE, ChTab);
    else if (c >= ChZero && c <= ChSeven) begin
      oct_acc  = c - ChZero;
      oct_left = (c <= ChThree) ? 2'd2 : 2'd1;
      lex_mode = MODE_OCT;
    end else if (c == ChLowX) lex_mode = MODE_HEX1;
    else begin
      add_token(KIND_SBYTE, ChBslash);
      string_char(c);
    end
  endfunction

  // an escape cut short comes out as the text seen so far
  function void spill_escape();
    case (lex_mode)
      MODE_ESC: add_token(KIND_SBYTE, ChBslash);
      MODE_OCT: add_token(KIND_SBYTE, oct_acc);
      MODE_HEX1: begin
        add_token(KIND_SBYTE, ChBslash);
        add_token(KIND_SBYTE, ChLowX);
      end
      MODE_HEX2: begin
        add_token(KIND_SBYTE, ChBslash);
        add_token(KIND_SBYTE, ChLowX);
        add_token(KIND_SBYTE, hex_held);
      end
      default: ;
    endcase
  endfunction

  function bit in_string();
    return lex_mode == MODE_STR || lex_mode == MODE_ESC || lex_mode == MODE_OCT ||
           lex_mode == MODE_HEX1 || lex_mode == MODE_HEX2;
  endfunction

  function void tokenize_byte(logic [7:0] c, logic eoi);
    int hi;
    int lo;
    logic [7:0] hv;
    step_tokens.delete();
    if (eoi) begin
      if (lex_mode == MODE_ATOM) begin
        add_token(KIND_AEND, 8'h00);
        add_token(KIND_EOI, 8'h00);
      end else if (in_string()) begin
        spill_escape();
        add_token(KIND_ERR, 8'h00);
      end else add_token(KIND_EOI, 8'h00);
      clear_lexer();
    end else begin
      case (lex_mode)
        MODE_COMMENT: begin
          if (c == ChNl) begin
            add_token(KIND_NL, 8'h00);
            lex_mode = MODE_IDLE;
          end
        end
        MODE_ATOM: begin
          if (skip_char(c) || c == ChNl || c == ChDquote || c == ChSquote ||
              c == ChOpen || c == ChClose || c == ChSemi) begin
            add_token(KIND_AEND, 8'h00);
            start_token(c);
          end else add_token(KIND_ABYTE, c);
        end
        MODE_STR: string_char(c);
        MODE_ESC: escape_char(c);
        MODE_OCT: begin
          if (c >= ChZero && c <= ChSeven && oct_left != 2'd0) begin
            oct_acc  = (oct_acc << 3) + (c - ChZero);
            oct_left = oct_left - 2'd1;
            if (oct_left == 2'd0) begin
              add_token(KIND_SBYTE, oct_acc);
              lex_mode = MODE_STR;
              oct_acc  = 8'h00;
            end
          end else begin
            spill_escape();
            oct_acc  = 8'h00;
            oct_left = 2'd0;
            string_char(c);
          end
        end
        MODE_HEX1: begin
          if (hex_digit(c) >= 0) begin
            hex_held = c;
            lex_mode = MODE_HEX2;
          end else begin
            spill_escape();
            string_char(c);
          end
        end
        MODE_HEX2: begin
          lo = hex_digit(c);
          if (lo >= 0) begin
            hi = hex_digit(hex_held);
            hv = 8'(hi * 16 + lo);
            add_token(KIND_SBYTE, hv);
            lex_mode = MODE_STR;
          end else begin
            spill_escape();
            string_char(c);
          end
          hex_held = 8'h00;
        end
        MODE_DEAD: ;
        default: start_token(c);
      endcase
    end
  endfunction

  task automatic flag_mismatch(input string field, input int got_v, input int want_v);
    $display("token %0d: %s is %0d, expected %0d", tokens_seen, field, got_v, want_v);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    token_t want;
    if (!rst_n) begin
      clear_lexer();
      tokens_due.delete();
      mismatches  = 0;
      tokens_seen = 0;
      items_seen  = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        tokenize_byte(in_tdata, in_tuser);
        foreach (step_tokens[i]) begin
          want      = step_tokens[i];
          want.last = (i == step_tokens.size() - 1);
          tokens_due.push_back(want);
        end
        items_seen++;
      end
      if (out_tvalid && out_tready) begin
        if (tokens_due.size() == 0) begin
          flag_mismatch("unexpected token, kind", int'(out_tuser), -1);
        end else begin
          want = tokens_due.pop_front();
          if (out_tuser != want.kind) flag_mismatch("kind", int'(out_tuser), int'(want.kind));
          if (out_tdata != want.value) flag_mismatch("byte", int'(out_tdata), int'(want.value));
          if (out_tlast != want.last) flag_mismatch("last", int'(out_tlast), int'(want.last));
        end
        tokens_seen++;
      end
    end
    tokens_waiting = tokens_due.size();
  end

endmodule

>>> verif/tb_top.sv
module tb_top;
  import sebt_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] in_byte
  logic       in_tuser;   // [0] is_end
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic [3:0] out_tuser;  // [3:0] kind
  logic       out_tlast;

  int mismatches;
  int tokens_waiting;
  int tokens_seen;
  int items_seen;

  // knobs for the feeder (idle_pct) and the sink (stall_pct), in percent of cycles
  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_left  = 0;   // cycles the sink still has to hold off
  int fed        = 0;   // items that count toward the random quota

  s_expression_byte_tokenizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sebt_token_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatches     (mismatches),
    .tokens_waiting (tokens_waiting),
    .tokens_seen    (tokens_seen),
    .items_seen     (items_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(12 * 200000);
    $display("timeout: tokenizer stream did not drain");
    $display("CHECKS FAILED");
    $finish;
  end

  // result sink: random stalls, plus a long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one item, idling first at random, and wait for the handshake
  task automatic feed(input logic [7:0] b, input logic eoi, input bit counts);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (counts) fed++;
  endtask

  // end mark; the byte lane carries junk that must be ignored
  task automatic feed_end();
    feed(8'($urandom_range(255)), 1'b1, 1'b1);
  endtask

  // any byte that keeps an atom going
  function automatic logic [7:0] atom_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == ChSpace || c == ChTab || c == ChVt || c == ChFf || c == ChCr ||
           c == ChNl || c == ChDquote || c == ChSquote || c == ChOpen ||
           c == ChClose || c == ChSemi)
      c = 8'($urandom_range(255));
    return c;
  endfunction

  // plain string text for a string opened with quote q
  function automatic logic [7:0] text_char(logic [7:0] q);
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == q || c == ChBslash || c == ChNl) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    case ($urandom_range(2))
      0:       return ChZero + 8'($urandom_range(9));
      1:       return ChLowA + 8'($urandom_range(5));
      default: return ChUpA + 8'($urandom_range(5));
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(4))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChVt;
      3:       return ChFf;
      default: return ChCr;
    endcase
  endfunction

  // a quoted string with random escapes; a broken one ends in a newline
  // or an end mark instead of its closing quote
  task automatic string_frag(input bit broken);
    logic [7:0] q;
    int n;
    int d;
    q = $urandom_range(1) ? ChSquote : ChDquote;
    feed(q, 1'b0, 1'b1);
    n = $urandom_range(6);
    repeat (n) begin
      case ($urandom_range(9))
        4: begin
          feed(ChBslash, 1'b0, 1'b1);
          case ($urandom_range(5))
            0:       feed(ChDquote, 1'b0, 1'b1);
            1:       feed(ChSquote, 1'b0, 1'b1);
            2:       feed(ChBslash, 1'b0, 1'b1);
            3:       feed(ChLowN, 1'b0, 1'b1);
            4:       feed(ChLowR, 1'b0, 1'b1);
            default: feed(ChLowT, 1'b0, 1'b1);
          endcase
        end
        5: begin
          // octal, full or cut short by whatever follows
          feed(ChBslash, 1'b0, 1'b1);
          d = $urandom_range(7);
          feed(ChZero + 8'(d), 1'b0, 1'b1);
          repeat ($urandom_range(d <= 3 ? 2 : 1)) feed(ChZero + 8'($urandom_range(7)), 1'b0, 1'b1);
        end
        6: begin
          feed(ChBslash, 1'b0, 1'b1);
          feed(ChLowX, 1'b0, 1'b1);
          feed(hex_char(), 1'b0, 1'b1);
          feed(hex_char(), 1'b0, 1'b1);
        end
        7: begin
          // hex escape with one or both digits missing, closed by a non-hex letter
          feed(ChBslash, 1'b0, 1'b1);
          feed(ChLowX, 1'b0, 1'b1);
          if ($urandom_range(1)) feed(hex_char(), 1'b0, 1'b1);
          feed(8'h67 + 8'($urandom_range(10)), 1'b0, 1'b1);
        end
        8: begin
          feed(ChBslash, 1'b0, 1'b1);
          feed(8'($urandom_range(255)), 1'b0, 1'b1);
        end
        default: feed(text_char(q), 1'b0, 1'b1);
      endcase
    end
    if (!broken) begin
      feed(q, 1'b0, 1'b1);
    end else if ($urandom_range(1)) begin
      // newline inside the string: error, then everything is dropped
      feed(ChNl, 1'b0, 1'b1);
      repeat ($urandom_range(3)) feed(8'($urandom_range(255)), 1'b0, 1'b0);
      feed_end();
    end else begin
      feed_end();
    end
  endtask

  // one well-formed chunk of source text most of the time, noise otherwise
  task automatic random_frag();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      repeat (1 + $urandom_range(4)) feed(atom_char(), 1'b0, 1'b1);
    end else if (pick < 50) begin
      string_frag(1'b0);
    end else if (pick < 60) begin
      case ($urandom_range(2))
        0:       feed(ChOpen, 1'b0, 1'b1);
        1:       feed(ChClose, 1'b0, 1'b1);
        default: feed(ChNl, 1'b0, 1'b1);
      endcase
    end else if (pick < 70) begin
      repeat (1 + $urandom_range(2)) feed(blank_char(), 1'b0, 1'b1);
    end else if (pick < 77) begin
      // comment body is dropped, only the closing newline counts
      feed(ChSemi, 1'b0, 1'b1);
      repeat ($urandom_range(4)) feed(text_char(ChNl), 1'b0, 1'b0);
      feed(ChNl, 1'b0, 1'b1);
    end else if (pick < 87) begin
      repeat (1 + $urandom_range(2)) feed(8'($urandom_range(255)), 1'b0, 1'b1);
    end else if (pick < 93) begin
      string_frag(1'b1);
    end else begin
      feed_end();
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tuser  <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: parens around an atom of extreme bytes, closed by ')'
    feed(ChOpen, 1'b0, 1'b1);
    feed(8'hff, 1'b0, 1'b1);
    feed(8'h00, 1'b0, 1'b1);
    feed(ChClose, 1'b0, 1'b1);
    // blanks and a comment
    feed(ChVt, 1'b0, 1'b1);
    feed(ChSemi, 1'b0, 1'b1);
    feed(8'h7a, 1'b0, 1'b1);
    feed(ChNl, 1'b0, 1'b1);
    // single-quoted: unknown escape, short hex escape, short octal escape
    feed(ChSquote, 1'b0, 1'b1);
    feed(ChBslash, 1'b0, 1'b1);
    feed(8'h39, 1'b0, 1'b1);
    feed(ChBslash, 1'b0, 1'b1);
    feed(ChLowX, 1'b0, 1'b1);
    feed(8'h34, 1'b0, 1'b1);
    feed(8'h67, 1'b0, 1'b1);
    feed(ChBslash, 1'b0, 1'b1);
    feed(8'h31, 1'b0, 1'b1);
    feed(8'h7a, 1'b0, 1'b1);
    feed(ChSquote, 1'b0, 1'b1);
    // newline inside a string with a hex escape pending, dropped byte,
    // then an end mark after the error
    feed(ChDquote, 1'b0, 1'b1);
    feed(ChBslash, 1'b0, 1'b1);
    feed(ChLowX, 1'b0, 1'b1);
    feed(ChNl, 1'b0, 1'b1);
    feed(8'h61, 1'b0, 1'b0);
    feed(8'h00, 1'b1, 1'b1);
    // end mark with an atom open, then end mark inside a string
    feed(8'h6b, 1'b0, 1'b1);
    feed(8'hff, 1'b1, 1'b1);
    feed(ChDquote, 1'b0, 1'b1);
    feed(8'h00, 1'b1, 1'b1);

    // random phases: no idling, idle sender, stalling sink, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      // long sink hold-off while the feeder keeps pushing, so the
      // result queue fills and input backs up
      if (phase == 0) hold_left = 90;
      fed = 0;
      while (fed < 70) random_frag();
    end
    in_tvalid <= 1'b0;

    // drain, then give stray tokens a chance to show up
    while (tokens_waiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run fed %0d items and checked %0d tokens over four idle/stall mixes,",
             items_seen, tokens_seen);
    $display("with a long sink hold-off, every escape form and unterminated strings");
    if (mismatches == 0 && tokens_waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
